### hw/rtl/sbcc_pkg.sv
// Shared constants of the sprite blitter with clipping and colour key.
`default_nettype none

package sbcc_pkg;

    // Fixed field widths
    localparam int CFG_DIM_W  = 11;
    localparam int CFG_ORG_W  = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int TEXEL_W    = 32;
    localparam int ADDR_W     = 22;
    localparam int ROW_W      = 10;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_MODE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_WIDTH = 3'd5;

    // Register reset values
    localparam logic [CFG_DIM_W-1:0] DEST_WIDTH_RST   = 11'd320;
    localparam logic [CFG_DIM_W-1:0] DEST_HEIGHT_RST  = 11'd240;
    localparam logic [CFG_DIM_W-1:0] SPRITE_WIDTH_RST = 11'd16;

    // Pixel format codes
    localparam logic MODE_1BPP = 1'b0;
    localparam logic MODE_4BPP = 1'b1;

    // Colour key: one-byte texels above this value are transparent
    localparam logic [7:0] KEY_LIMIT = 8'd64;
    // Byte that carries alpha in four-byte mode
    localparam int ALPHA_BYTE = 3;

endpackage

`default_nettype wire

### hw/rtl/sprite_blit_clip_colorkey_unit.sv
// Sprite blitter: clips and colour-keys a texel stream into frame buffer writes.
//
// Texels of one sprite enter on the in channel (in_valid/in_ready) in raster
// order, texel_value with last_texel on the final texel. Column and row
// counters place each texel at origin plus its position in the sprite. Texels
// that fall outside the destination, or that are transparent, give no item;
// every other texel gives one write_address/write_data item on the out channel
// (out_valid/out_ready).
// Throughput: one texel per cycle while out_ready stays high. A texel passes
// the input stage register, which holds the screen position, and then the
// output register, which takes the clip test, row multiply and address.
// Stalls: the output register holds a waiting item while out_ready is low; the
// input stage still takes one more texel, after which in_ready follows out_ready.
// Configuration: cfg_write with cfg_index and cfg_data writes one register;
// indexes 6 and 7 are ignored. Write only while no item is in flight.
// Reset: registers return to 320 x 240, one byte per pixel, origin 0, sprite
// width 16; both counters clear and both stages empty.
`default_nettype none

module sprite_blit_clip_colorkey_unit #(
    parameter int MAX_DEST_WIDTH   = 1024,
    parameter int MAX_DEST_HEIGHT  = 1024,
    parameter int MAX_SPRITE_WIDTH = 1024
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire logic [sbcc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [sbcc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [sbcc_pkg::TEXEL_W-1:0]       texel_value,
    input  wire logic                               last_texel,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [sbcc_pkg::ADDR_W-1:0]             write_address,
    output logic [sbcc_pkg::TEXEL_W-1:0]            write_data
);

    localparam int DIM_W = sbcc_pkg::CFG_DIM_W;
    localparam int ORG_W = sbcc_pkg::CFG_ORG_W;
    localparam int COL_W = $clog2(MAX_SPRITE_WIDTH);
    localparam int SW_W  = $clog2(MAX_SPRITE_WIDTH + 1);
    localparam int SWC_W = (SW_W > DIM_W) ? SW_W : DIM_W;
    localparam int DW_W  = $clog2(MAX_DEST_WIDTH + 1);
    localparam int DWC_W = (DW_W > DIM_W) ? DW_W : DIM_W;
    localparam int DH_W  = $clog2(MAX_DEST_HEIGHT + 1);
    localparam int DHC_W = (DH_W > DIM_W) ? DH_W : DIM_W;
    localparam int XA_W  = (COL_W > ORG_W) ? COL_W : ORG_W;
    localparam int X_W   = XA_W + 1;
    localparam int YA_W  = (sbcc_pkg::ROW_W > ORG_W) ? sbcc_pkg::ROW_W : ORG_W;
    localparam int Y_W   = YA_W + 1;
    localparam int XC_W  = (X_W > DW_W) ? X_W : DW_W;
    localparam int YC_W  = (Y_W > DH_W) ? Y_W : DH_W;
    localparam int P_W   = DW_W + DH_W + 1;
    localparam int PA_W  = P_W + 2;
    localparam int A_W   = (PA_W > sbcc_pkg::ADDR_W) ? PA_W : sbcc_pkg::ADDR_W;

    // Configuration registers
    logic [DIM_W-1:0] dest_width_reg;
    logic [DIM_W-1:0] dest_height_reg;
    logic             pixel_mode_reg;
    logic [ORG_W-1:0] origin_x_reg;
    logic [ORG_W-1:0] origin_y_reg;
    logic [DIM_W-1:0] sprite_width_reg;

    // Sprite position counters
    logic [COL_W-1:0]           column_count_reg;
    logic [COL_W-1:0]           column_count_next;
    logic [sbcc_pkg::ROW_W-1:0] row_count_reg;
    logic [sbcc_pkg::ROW_W-1:0] row_count_next;

    // Input stage
    logic                         s1_valid_reg;
    logic [sbcc_pkg::TEXEL_W-1:0] s1_texel_reg;
    logic [X_W-1:0]               s1_x_reg;
    logic [Y_W-1:0]               s1_y_reg;
    logic [X_W-1:0]               x_next;
    logic [Y_W-1:0]               y_next;

    // Output register
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [sbcc_pkg::ADDR_W-1:0]  write_address_reg;
    logic [sbcc_pkg::ADDR_W-1:0]  write_address_next;
    logic [sbcc_pkg::TEXEL_W-1:0] write_data_reg;
    logic [sbcc_pkg::TEXEL_W-1:0] write_data_next;

    logic             accept;
    logic             s1_adv;
    logic [SWC_W-1:0] sw_ext;
    logic [SWC_W-1:0] sw_clamp;
    logic [SWC_W-1:0] sw_eff;
    logic [SWC_W-1:0] col_inc;
    logic             col_wrap;
    logic [DWC_W-1:0] dw_ext;
    logic [DW_W-1:0]  dw;
    logic [DHC_W-1:0] dh_ext;
    logic [DH_W-1:0]  dh;
    logic             on_screen;
    logic             clear;
    logic [DW_W-1:0]  x_idx;
    logic [DH_W-1:0]  y_idx;
    logic [A_W-1:0]   pix_idx;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_width_reg   <= sbcc_pkg::DEST_WIDTH_RST;
            dest_height_reg  <= sbcc_pkg::DEST_HEIGHT_RST;
            pixel_mode_reg   <= sbcc_pkg::MODE_1BPP;
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            sprite_width_reg <= sbcc_pkg::SPRITE_WIDTH_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                sbcc_pkg::CFG_DEST_WIDTH:   dest_width_reg   <= cfg_data[DIM_W-1:0];
                sbcc_pkg::CFG_DEST_HEIGHT:  dest_height_reg  <= cfg_data[DIM_W-1:0];
                sbcc_pkg::CFG_PIXEL_MODE:   pixel_mode_reg   <= cfg_data[0];
                sbcc_pkg::CFG_ORIGIN_X:     origin_x_reg     <= cfg_data[ORG_W-1:0];
                sbcc_pkg::CFG_ORIGIN_Y:     origin_y_reg     <= cfg_data[ORG_W-1:0];
                sbcc_pkg::CFG_SPRITE_WIDTH: sprite_width_reg <= cfg_data[DIM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------- handshake
    assign s1_adv   = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s1_adv;
    assign accept   = in_valid && in_ready;

    // -------------------------------------------------------------- counters
    always_comb
    begin
        // Saturate to the build limit; a zero width acts as one
        sw_ext   = SWC_W'(sprite_width_reg);
        sw_clamp = (sw_ext > SWC_W'(MAX_SPRITE_WIDTH)) ? SWC_W'(MAX_SPRITE_WIDTH) : sw_ext;
        sw_eff   = (sw_clamp == '0) ? SWC_W'(1) : sw_clamp;
        col_inc  = SWC_W'(column_count_reg) + SWC_W'(1);
        col_wrap = col_inc >= sw_eff;

        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        if (accept)
        begin
            if (last_texel)
            begin
                column_count_next = '0;
                row_count_next    = '0;
            end
            else if (col_wrap)
            begin
                column_count_next = '0;
                row_count_next    = row_count_reg + 1'b1;
            end
            else
            begin
                column_count_next = COL_W'(col_inc);
            end
        end

        x_next = X_W'($signed(origin_x_reg)) + X_W'(column_count_reg);
        y_next = Y_W'($signed(origin_y_reg)) + Y_W'(row_count_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
        end
        else
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
        end
    end

    // ----------------------------------------------------------- input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_texel_reg <= texel_value;
            s1_x_reg     <= x_next;
            s1_y_reg     <= y_next;
        end
    end

    // ---------------------------------------------- clip, key and address
    always_comb
    begin
        dw_ext = DWC_W'(dest_width_reg);
        dw     = DW_W'((dw_ext > DWC_W'(MAX_DEST_WIDTH)) ? DWC_W'(MAX_DEST_WIDTH) : dw_ext);
        dh_ext = DHC_W'(dest_height_reg);
        dh     = DH_W'((dh_ext > DHC_W'(MAX_DEST_HEIGHT)) ? DHC_W'(MAX_DEST_HEIGHT) : dh_ext);

        // A negative position has its top bit set and so compares above any size
        on_screen = (XC_W'(s1_x_reg) < XC_W'(dw)) && (YC_W'(s1_y_reg) < YC_W'(dh));

        if (pixel_mode_reg == sbcc_pkg::MODE_4BPP)
            clear = s1_texel_reg[8*sbcc_pkg::ALPHA_BYTE +: 8] == 8'd0;
        else
            clear = s1_texel_reg[7:0] > sbcc_pkg::KEY_LIMIT;

        x_idx   = DW_W'(s1_x_reg);
        y_idx   = DH_W'(s1_y_reg);
        pix_idx = A_W'(y_idx) * A_W'(dw) + A_W'(x_idx);

        if (pixel_mode_reg == sbcc_pkg::MODE_4BPP)
        begin
            write_address_next = sbcc_pkg::ADDR_W'(pix_idx << 2);
            write_data_next    = s1_texel_reg;
        end
        else
        begin
            write_address_next = sbcc_pkg::ADDR_W'(pix_idx);
            write_data_next    = {{(sbcc_pkg::TEXEL_W-8){1'b0}}, s1_texel_reg[7:0]};
        end

        out_valid_next = s1_valid_reg && on_screen && !clear;
    end

    // ------------------------------------------------------- output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && out_valid_next)
        begin
            write_address_reg <= write_address_next;
            write_data_reg    <= write_data_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign write_address = write_address_reg;
    assign write_data    = write_data_reg;

    // ------------------------------------------------------------ assertions
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (!s1_valid_reg && !out_valid_reg) |-> in_ready)
        else $error("in_ready low with both stages empty");

    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_x_reg) && $stable(s1_y_reg)))
        else $error("input stage item lost during stall");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_texel) |=> (column_count_reg == '0 && row_count_reg == '0))
        else $error("counters not cleared after last texel");

    a_col_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !last_texel && !col_wrap)
        |=> (column_count_reg == COL_W'($past(column_count_reg) + 1'b1)
             && $stable(row_count_reg)))
        else $error("column counter failed to advance");

endmodule

`default_nettype wire

### tb/tb_sprite_blit_clip_colorkey_unit.sv
// Testbench for the sprite blitter: texel stream in, predicted frame buffer writes checked out.
`default_nettype none

module tb_sprite_blit_clip_colorkey_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM         = 1024;
    localparam int LONG_HOLD       = 200;
    localparam int DRAIN_CYCLES    = 6;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int PHASE_TEXELS    = 40;
    localparam int RANDOM_PHASES   = 10;
    localparam int LONG_RUN        = 60;
    localparam int MAX_SPRITE_RUN  = 80;
    localparam logic [sbcc_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [sbcc_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [sbcc_pkg::TEXEL_W-1:0] value;
        logic                         last;
    } texel_item_t;

    typedef struct packed {
        logic [sbcc_pkg::ADDR_W-1:0]  addr;
        logic [sbcc_pkg::TEXEL_W-1:0] data;
    } frame_write_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_write = 1'b0;
    logic [sbcc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [sbcc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic [sbcc_pkg::TEXEL_W-1:0]    texel_value = '0;
    logic                            last_texel = 1'b0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [sbcc_pkg::ADDR_W-1:0]     write_address;
    logic [sbcc_pkg::TEXEL_W-1:0]    write_data;

    // Shadow of the block's registers and counters
    logic [sbcc_pkg::CFG_DIM_W-1:0]        shadow_dw = sbcc_pkg::DEST_WIDTH_RST;
    logic [sbcc_pkg::CFG_DIM_W-1:0]        shadow_dh = sbcc_pkg::DEST_HEIGHT_RST;
    logic                                  shadow_mode = sbcc_pkg::MODE_1BPP;
    logic signed [sbcc_pkg::CFG_ORG_W-1:0] shadow_ox = '0;
    logic signed [sbcc_pkg::CFG_ORG_W-1:0] shadow_oy = '0;
    logic [sbcc_pkg::CFG_DIM_W-1:0]        shadow_sw = sbcc_pkg::SPRITE_WIDTH_RST;
    logic [sbcc_pkg::ROW_W-1:0]            column_pos = '0;
    logic [sbcc_pkg::ROW_W-1:0]            row_pos = '0;

    texel_item_t  texel_queue[$];
    frame_write_t pending_writes[$];
    texel_item_t  next_texel;
    frame_write_t due_write;

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_req = 1'b0;
    bit          hold_seen = 1'b0;
    int          hold_left = 0;
    int          fail_count = 0;
    int unsigned cycle_count = 0;

    sprite_blit_clip_colorkey_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .texel_value   (texel_value),
        .last_texel    (last_texel),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .write_address (write_address),
        .write_data    (write_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("sprite_blit_clip_colorkey_unit test failed");
            $finish;
        end
    end

    // Place one texel, queue its write if it lands and is opaque, advance the counters
    task automatic blit_texel(input logic [sbcc_pkg::TEXEL_W-1:0] tex, input logic last);
        int dw;
        int dh;
        int sw;
        int x;
        int y;
        int addr;
        bit see_through;
        frame_write_t w;
        dw = (shadow_dw > MAX_DIM) ? MAX_DIM : int'(shadow_dw);
        dh = (shadow_dh > MAX_DIM) ? MAX_DIM : int'(shadow_dh);
        sw = (shadow_sw > MAX_DIM) ? MAX_DIM : int'(shadow_sw);
        x = int'(shadow_ox) + int'(column_pos);
        y = int'(shadow_oy) + int'(row_pos);
        if (shadow_mode == sbcc_pkg::MODE_1BPP)
            see_through = tex[7:0] > sbcc_pkg::KEY_LIMIT;
        else
            see_through = tex[8*sbcc_pkg::ALPHA_BYTE +: 8] == 8'd0;
        if (x >= 0 && y >= 0 && x < dw && y < dh && !see_through)
        begin
            addr = ((shadow_mode == sbcc_pkg::MODE_4BPP) ? 4 : 1) * (x + y * dw);
            w.addr = addr[sbcc_pkg::ADDR_W-1:0];
            w.data = (shadow_mode == sbcc_pkg::MODE_4BPP) ? tex : {24'd0, tex[7:0]};
            pending_writes.push_back(w);
        end
        if (sw == 0)
            sw = 1;
        if (last)
        begin
            column_pos = '0;
            row_pos = '0;
        end
        else if (int'(column_pos) + 1 >= sw)
        begin
            column_pos = '0;
            row_pos = row_pos + 1'b1;
        end
        else
            column_pos = column_pos + 1'b1;
    endtask

    // Texel source
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            texel_value <= '0;
            last_texel <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                blit_texel(texel_value, last_texel);
            if (!in_valid || in_ready)
            begin
                if (texel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_texel = texel_queue.pop_front();
                    in_valid <= 1'b1;
                    texel_value <= next_texel.value;
                    last_texel <= next_texel.last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted in cycles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_seen <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= LONG_HOLD;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Write sink and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_writes.size() == 0)
                begin
                    $error("unexpected write: write_address %0h write_data %0h",
                           write_address, write_data);
                    fail_count++;
                end
                else
                begin
                    due_write = pending_writes.pop_front();
                    if (write_address !== due_write.addr)
                    begin
                        $error("write_address: expected %0h, got %0h",
                               due_write.addr, write_address);
                        fail_count++;
                    end
                    if (write_data !== due_write.data)
                    begin
                        $error("write_data: expected %0h, got %0h",
                               due_write.data, write_data);
                        fail_count++;
                    end
                end
            end
            if (hold_req != hold_seen || hold_left != 0)
                out_ready <= 1'b0;
            else
                out_ready <= $urandom_range(99) >= recv_stall_pct;
        end
    end

    task automatic write_reg(input logic [sbcc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sbcc_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            sbcc_pkg::CFG_DEST_WIDTH:   shadow_dw = data[sbcc_pkg::CFG_DIM_W-1:0];
            sbcc_pkg::CFG_DEST_HEIGHT:  shadow_dh = data[sbcc_pkg::CFG_DIM_W-1:0];
            sbcc_pkg::CFG_PIXEL_MODE:   shadow_mode = data[0];
            sbcc_pkg::CFG_ORIGIN_X:     shadow_ox = data[sbcc_pkg::CFG_ORG_W-1:0];
            sbcc_pkg::CFG_ORIGIN_Y:     shadow_oy = data[sbcc_pkg::CFG_ORG_W-1:0];
            sbcc_pkg::CFG_SPRITE_WIDTH: shadow_sw = data[sbcc_pkg::CFG_DIM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] dw, input logic [15:0] dh, input logic mode,
                              input logic [15:0] ox, input logic [15:0] oy,
                              input logic [15:0] sw);
        write_reg(sbcc_pkg::CFG_DEST_WIDTH, dw);
        write_reg(sbcc_pkg::CFG_DEST_HEIGHT, dh);
        write_reg(sbcc_pkg::CFG_PIXEL_MODE, {15'd0, mode});
        write_reg(sbcc_pkg::CFG_ORIGIN_X, ox);
        write_reg(sbcc_pkg::CFG_ORIGIN_Y, oy);
        write_reg(sbcc_pkg::CFG_SPRITE_WIDTH, sw);
        // spare indexes must leave everything untouched
        write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, 16'($urandom()));
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_idling(input int mode);
        @(negedge clk);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
            default: begin send_idle_pct = 18; recv_stall_pct = 18; end
        endcase
    endtask

    // Hold until every write has come out and the pipeline has emptied
    task automatic wait_drained();
        do
            @(negedge clk);
        while (texel_queue.size() != 0 || in_valid || pending_writes.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [sbcc_pkg::TEXEL_W-1:0] random_texel();
        logic [sbcc_pkg::TEXEL_W-1:0] v;
        v = $urandom();
        if (shadow_mode == sbcc_pkg::MODE_1BPP)
        begin
            if ($urandom_range(99) < 70)
                v[7:0] = 8'($urandom_range(64));
        end
        else if ($urandom_range(99) < 20)
            v[8*sbcc_pkg::ALPHA_BYTE +: 8] = 8'd0;
        return v;
    endfunction

    task automatic queue_run(input int len);
        for (int i = 0; i < len; i++)
            texel_queue.push_back('{random_texel(), i == len - 1});
    endtask

    // Mostly sprites of one to four rows, cut to MAX_SPRITE_RUN texels; the rest broken runs
    task automatic queue_random_texels(input int count);
        int n;
        int len;
        int sw;
        n = 0;
        while (n < count)
        begin
            sw = (shadow_sw > MAX_DIM) ? MAX_DIM : int'(shadow_sw);
            if (sw == 0)
                sw = 1;
            if ($urandom_range(99) < 80)
            begin
                len = sw * $urandom_range(4, 1);
                if (len > MAX_SPRITE_RUN)
                    len = MAX_SPRITE_RUN;
                queue_run(len);
            end
            else
            begin
                len = $urandom_range(12, 1);
                for (int i = 0; i < len; i++)
                    texel_queue.push_back('{random_texel(), $urandom_range(7) == 0});
            end
            n += len;
        end
    endtask

    function automatic logic [15:0] pick_dim();
        case ($urandom_range(9))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'(MAX_DIM);
            3: return 16'($urandom_range(2047, MAX_DIM + 1));
            default: return 16'($urandom_range(40, 2));
        endcase
    endfunction

    function automatic logic [15:0] pick_origin();
        int o;
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom());
            default:
            begin
                o = int'($urandom_range(40)) - 20;
                return o[15:0];
            end
        endcase
    endfunction

    function automatic logic [15:0] pick_sprite_width();
        case ($urandom_range(7))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'($urandom_range(2047, MAX_DIM + 1));
            default: return 16'($urandom_range(12, 2));
        endcase
    endfunction

    initial
    begin
        logic [sbcc_pkg::TEXEL_W-1:0] tex;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: colour key boundary and upper bytes dropped in one-byte mode
        set_idling(0);
        texel_queue.push_back('{32'h0000_0000, 1'b0});
        texel_queue.push_back('{32'hFFFF_FF40, 1'b0});
        texel_queue.push_back('{32'h0000_0041, 1'b0});
        texel_queue.push_back('{32'hFFFF_FFFF, 1'b0});
        texel_queue.push_back('{32'h5A5A_A500, 1'b1});
        wait_drained();

        // Tiny destination with the sprite hanging over every edge, four-byte mode
        set_config(16'd3, 16'd1, sbcc_pkg::MODE_4BPP, 16'hFFFF, 16'hFFFF, 16'd5);
        set_idling(3);
        for (int i = 0; i < 15; i++)
        begin
            tex = $urandom();
            case (i % 4)
                0: tex[31:24] = 8'h00;
                1: tex[31:24] = 8'h01;
                2: tex[31:24] = 8'hFF;
                default: if (tex[31:24] == 8'h00) tex[31:24] = 8'h80;
            endcase
            texel_queue.push_back('{tex, i == 14});
        end
        wait_drained();

        // Fully clipped extremes
        set_config(16'd0, 16'(MAX_DIM), sbcc_pkg::MODE_1BPP, 16'h8000, 16'h7FFF, 16'd1);
        queue_random_texels(20);
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_config(pick_dim(), pick_dim(), 1'($urandom_range(1)), pick_origin(),
                       pick_origin(), pick_sprite_width());
            set_idling(p % 4);
            queue_random_texels(PHASE_TEXELS);
            wait_drained();
        end

        // Oversized registers saturate: rows are laid out at the largest destination width
        set_config(16'd2047, 16'd2047, sbcc_pkg::MODE_1BPP, 16'd0, 16'd2, 16'd2047);
        set_idling(0);
        // long receiver hold-off while the source keeps offering
        hold_req = ~hold_req;
        queue_run(LONG_RUN);
        wait_drained();

        // Zero sprite width acts as one: rows run past the bottom
        set_config(16'(MAX_DIM), 16'(MAX_DIM), sbcc_pkg::MODE_4BPP, 16'(MAX_DIM - 1),
                   16'(MAX_DIM - 40), 16'd0);
        set_idling(3);
        queue_run(LONG_RUN);
        wait_drained();

        if (fail_count == 0 && pending_writes.size() == 0)
            $display("sprite_blit_clip_colorkey_unit test passed");
        else
            $display("sprite_blit_clip_colorkey_unit test failed");
        $finish;
    end

endmodule

`default_nettype wire

### sprite_blit_clip_colorkey_unit.f
hw/rtl/sbcc_pkg.sv
hw/rtl/sprite_blit_clip_colorkey_unit.sv
tb/tb_sprite_blit_clip_colorkey_unit.sv
